### src/radial_distortion_remap_top_assert.svh
// Assertion macros for the radial distortion remap checkers.
// Both expect clk and rst_n in the scope where they are used.
`ifndef RADIAL_DISTORTION_REMAP_TOP_ASSERT_SVH
`define RADIAL_DISTORTION_REMAP_TOP_ASSERT_SVH

// Same-cycle implication.
`define RDM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdm assertion failed");

// Next-cycle implication.
`define RDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdm assertion failed");

`endif

### src/rdm_pkg.sv
`default_nettype none

package rdm_pkg;

    localparam int COORD_BITS = 12;

    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int CENTER_W = 20;
    localparam int INV_W    = 32;
    localparam int COEF_W   = 24;
    localparam int FRAME_W  = 24;
    localparam int DIM_W    = 12;

    // offset magnitude in Q.8
    localparam int MAG_W = (COORD_BITS + 8 > CENTER_W) ? COORD_BITS + 8 : CENTER_W;
    localparam int DX_W  = MAG_W + 1;
    localparam int R2_W  = 32;
    localparam int ACC_W = 32;

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_INV_FX_SQ = 3'd2,
        REG_INV_FY_SQ = 3'd3,
        REG_COEF_K1   = 3'd4,
        REG_COEF_K2   = 3'd5,
        REG_COEF_K3   = 3'd6,
        REG_FRAME     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CENTER_W-1:0]      center_x;
        logic [CENTER_W-1:0]      center_y;
        logic [INV_W-1:0]         inv_focal_x_sq;
        logic [INV_W-1:0]         inv_focal_y_sq;
        logic signed [COEF_W-1:0] coef_k1;
        logic signed [COEF_W-1:0] coef_k2;
        logic signed [COEF_W-1:0] coef_k3;
        logic [FRAME_W-1:0]       frame_size;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_col;
        logic [COORD_BITS-1:0] dest_row;
    } dest_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] source_col;
        logic [COORD_BITS-1:0] source_row;
        logic                  in_frame;
    } src_t;

    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic [R2_W-1:0]        r2;
    } rad_t;

    typedef struct packed {
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
        logic signed [ACC_W-1:0] scale;
    } poly_t;

endpackage

`default_nettype wire

### src/rdm_regs.sv
`default_nettype none

module rdm_regs
    import rdm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CENTER_X:  cfg_reg.center_x       <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:  cfg_reg.center_y       <= pwdata[CENTER_W-1:0];
                REG_INV_FX_SQ: cfg_reg.inv_focal_x_sq <= pwdata[INV_W-1:0];
                REG_INV_FY_SQ: cfg_reg.inv_focal_y_sq <= pwdata[INV_W-1:0];
                REG_COEF_K1:   cfg_reg.coef_k1        <= $signed(pwdata[COEF_W-1:0]);
                REG_COEF_K2:   cfg_reg.coef_k2        <= $signed(pwdata[COEF_W-1:0]);
                REG_COEF_K3:   cfg_reg.coef_k3        <= $signed(pwdata[COEF_W-1:0]);
                REG_FRAME:     cfg_reg.frame_size     <= pwdata[FRAME_W-1:0];
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_CENTER_X:  prdata = CFG_W'(cfg_reg.center_x);
            REG_CENTER_Y:  prdata = CFG_W'(cfg_reg.center_y);
            REG_INV_FX_SQ: prdata = CFG_W'(cfg_reg.inv_focal_x_sq);
            REG_INV_FY_SQ: prdata = CFG_W'(cfg_reg.inv_focal_y_sq);
            REG_COEF_K1:   prdata = CFG_W'($unsigned(cfg_reg.coef_k1));
            REG_COEF_K2:   prdata = CFG_W'($unsigned(cfg_reg.coef_k2));
            REG_COEF_K3:   prdata = CFG_W'($unsigned(cfg_reg.coef_k3));
            REG_FRAME:     prdata = CFG_W'(cfg_reg.frame_size);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/rdm_radius.sv
`default_nettype none

module rdm_radius
    import rdm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire dest_t up_data,
    input  wire cfg_t  cfg,
    output logic       dn_valid,
    input  wire logic  dn_stall,
    output rad_t       dn_data
);

    localparam int NSTG     = 6;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SQ_LO_W  = 24;
    localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
    localparam int PLO_W    = SQ_LO_W + INV_W;
    localparam int PHI_W    = SQ_HI_W + INV_W;
    localparam int TS_W     = PHI_W + 1;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   adv;

    logic [MAG_W-1:0]       col_q8, row_q8, cx, cy;
    logic signed [DX_W-1:0] dx_next, dy_next;
    logic signed [DX_W-1:0] dx_reg [NSTG];
    logic signed [DX_W-1:0] dy_reg [NSTG];
    logic [MAG_W-1:0]       mx_next, my_next, mx_reg, my_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [PLO_W-1:0]       plox_reg, ploy_reg;
    logic [PHI_W-1:0]       phix_reg, phiy_reg;
    logic [TS_W-1:0]        tsum_x, tsum_y;
    logic [R2_W-1:0]        termx_next, termy_next, termx_reg, termy_reg;
    logic [R2_W:0]          rsum;
    logic [R2_W-1:0]        r2_next, r2_reg;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NSTG] = !dn_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vld_next = {vld_reg[NSTG-2:0], up_valid};
    assign up_stall = !adv[0];
    assign dn_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_comb
    begin
        col_q8  = MAG_W'({up_data.dest_col, 8'h00});
        row_q8  = MAG_W'({up_data.dest_row, 8'h00});
        cx      = MAG_W'(cfg.center_x);
        cy      = MAG_W'(cfg.center_y);
        dx_next = $signed({1'b0, col_q8}) - $signed({1'b0, cx});
        dy_next = $signed({1'b0, row_q8}) - $signed({1'b0, cy});

        mx_next = dx_reg[0][DX_W-1] ? MAG_W'(-dx_reg[0]) : MAG_W'(dx_reg[0]);
        my_next = dy_reg[0][DX_W-1] ? MAG_W'(-dy_reg[0]) : MAG_W'(dy_reg[0]);

        // floor(d^2 * inv / 2^24), clamp to 32 bits
        tsum_x     = TS_W'(phix_reg) + TS_W'(plox_reg >> SQ_LO_W);
        tsum_y     = TS_W'(phiy_reg) + TS_W'(ploy_reg >> SQ_LO_W);
        termx_next = (|tsum_x[TS_W-1:R2_W]) ? '1 : tsum_x[R2_W-1:0];
        termy_next = (|tsum_y[TS_W-1:R2_W]) ? '1 : tsum_y[R2_W-1:0];

        rsum    = {1'b0, termx_reg} + {1'b0, termy_reg};
        r2_next = rsum[R2_W] ? '1 : rsum[R2_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg[0] <= dx_next;
            dy_reg[0] <= dy_next;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (adv[k])
            begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
            end
        end
        if (adv[1])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
        if (adv[2])
        begin
            sqx_reg <= SQ_W'(mx_reg) * SQ_W'(mx_reg);
            sqy_reg <= SQ_W'(my_reg) * SQ_W'(my_reg);
        end
        if (adv[3])
        begin
            // split the square so each product stays narrow
            plox_reg <= PLO_W'(sqx_reg[SQ_LO_W-1:0]) * PLO_W'(cfg.inv_focal_x_sq);
            phix_reg <= PHI_W'(sqx_reg[SQ_W-1:SQ_LO_W]) * PHI_W'(cfg.inv_focal_x_sq);
            ploy_reg <= PLO_W'(sqy_reg[SQ_LO_W-1:0]) * PLO_W'(cfg.inv_focal_y_sq);
            phiy_reg <= PHI_W'(sqy_reg[SQ_W-1:SQ_LO_W]) * PHI_W'(cfg.inv_focal_y_sq);
        end
        if (adv[4])
        begin
            termx_reg <= termx_next;
            termy_reg <= termy_next;
        end
        if (adv[5])
        begin
            r2_reg <= r2_next;
        end
    end

    always_comb
    begin
        dn_data.dx = dx_reg[NSTG-1];
        dn_data.dy = dy_reg[NSTG-1];
        dn_data.r2 = r2_reg;
    end

endmodule

`default_nettype wire

### src/rdm_poly.sv
`default_nettype none

module rdm_poly
    import rdm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_stall,
    input  wire rad_t up_data,
    input  wire cfg_t cfg,
    output logic      dn_valid,
    input  wire logic dn_stall,
    output poly_t     dn_data
);

    localparam int NSTEP    = 3;
    localparam int NSTG     = 2 * NSTEP;
    localparam int TRUNC_SH = 24;
    localparam int PR_W     = ACC_W + R2_W + 1;
    localparam int TQ_W     = PR_W - TRUNC_SH;
    localparam int SUM_W    = TQ_W + 1;

    localparam logic signed [PR_W-1:0]  RND_BIAS =
        {{(PR_W - TRUNC_SH){1'b0}}, {TRUNC_SH{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_HI   =
        {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO   = -SAT_HI;
    localparam logic signed [ACC_W-1:0] ONE_Q20  = ACC_W'(1) << 20;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   adv;

    logic signed [ACC_W-1:0] src_acc  [NSTEP];
    logic [R2_W-1:0]         src_r2   [NSTEP];
    logic signed [DX_W-1:0]  src_dx   [NSTEP];
    logic signed [DX_W-1:0]  src_dy   [NSTEP];
    logic signed [ACC_W-1:0] addend   [NSTEP];
    logic signed [PR_W-1:0]  prod_next[NSTEP];
    logic signed [PR_W-1:0]  rnd      [NSTEP];
    logic signed [TQ_W-1:0]  trq      [NSTEP];
    logic signed [SUM_W-1:0] ssum     [NSTEP];
    logic signed [ACC_W-1:0] acc_next [NSTEP];

    logic signed [PR_W-1:0]  prod_reg [NSTEP];
    logic [R2_W-1:0]         mr2_reg  [NSTEP];
    logic signed [DX_W-1:0]  mdx_reg  [NSTEP];
    logic signed [DX_W-1:0]  mdy_reg  [NSTEP];
    logic signed [ACC_W-1:0] acc_reg  [NSTEP];
    logic [R2_W-1:0]         ar2_reg  [NSTEP];
    logic signed [DX_W-1:0]  adx_reg  [NSTEP];
    logic signed [DX_W-1:0]  ady_reg  [NSTEP];

    always_comb
    begin
        adv[NSTG] = !dn_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vld_next = {vld_reg[NSTG-2:0], up_valid};
    assign up_stall = !adv[0];
    assign dn_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Horner: acc = k3, then k2 + acc*r2, k1 + acc*r2, 1.0 + acc*r2
    always_comb
    begin
        src_acc[0] = {{(ACC_W - COEF_W){cfg.coef_k3[COEF_W-1]}}, cfg.coef_k3};
        src_r2[0]  = up_data.r2;
        src_dx[0]  = up_data.dx;
        src_dy[0]  = up_data.dy;
        for (int j = 1; j < NSTEP; j++)
        begin
            src_acc[j] = acc_reg[j-1];
            src_r2[j]  = ar2_reg[j-1];
            src_dx[j]  = adx_reg[j-1];
            src_dy[j]  = ady_reg[j-1];
        end

        addend[0] = {{(ACC_W - COEF_W){cfg.coef_k2[COEF_W-1]}}, cfg.coef_k2};
        addend[1] = {{(ACC_W - COEF_W){cfg.coef_k1[COEF_W-1]}}, cfg.coef_k1};
        addend[2] = ONE_Q20;

        for (int j = 0; j < NSTEP; j++)
        begin
            prod_next[j] = src_acc[j] * $signed({1'b0, src_r2[j]});
            // round toward zero before the shift
            rnd[j]  = prod_reg[j] + (prod_reg[j][PR_W-1] ? RND_BIAS : '0);
            trq[j]  = TQ_W'(rnd[j] >>> TRUNC_SH);
            ssum[j] = SUM_W'(trq[j]) + SUM_W'(addend[j]);
            if (ssum[j] > SAT_HI)
            begin
                acc_next[j] = ACC_W'(SAT_HI);
            end
            else if (ssum[j] < SAT_LO)
            begin
                acc_next[j] = ACC_W'(SAT_LO);
            end
            else
            begin
                acc_next[j] = ACC_W'(ssum[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NSTEP; j++)
        begin
            if (adv[2*j])
            begin
                prod_reg[j] <= prod_next[j];
                mr2_reg[j]  <= src_r2[j];
                mdx_reg[j]  <= src_dx[j];
                mdy_reg[j]  <= src_dy[j];
            end
            if (adv[2*j+1])
            begin
                acc_reg[j] <= acc_next[j];
                ar2_reg[j] <= mr2_reg[j];
                adx_reg[j] <= mdx_reg[j];
                ady_reg[j] <= mdy_reg[j];
            end
        end
    end

    always_comb
    begin
        dn_data.dx    = adx_reg[NSTEP-1];
        dn_data.dy    = ady_reg[NSTEP-1];
        dn_data.scale = acc_reg[NSTEP-1];
    end

endmodule

`default_nettype wire

### src/rdm_project.sv
`default_nettype none

module rdm_project
    import rdm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire poly_t up_data,
    input  wire cfg_t  cfg,
    output logic       dn_valid,
    input  wire logic  dn_stall,
    output src_t       dn_data
);

    localparam int NSTG   = 5;
    localparam int OFF_SH = 20;
    localparam int POS_SH = 8;
    localparam int PX_W   = DX_W + ACC_W;
    localparam int OFF_W  = PX_W - OFF_SH;
    localparam int POS_W  = OFF_W + 1;
    localparam int SX_W   = POS_W - POS_SH;

    localparam logic signed [PX_W-1:0]  OFF_BIAS =
        {{(PX_W - OFF_SH){1'b0}}, {OFF_SH{1'b1}}};
    localparam logic signed [POS_W-1:0] POS_BIAS =
        {{(POS_W - POS_SH){1'b0}}, {POS_SH{1'b1}}};

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   adv;

    logic signed [PX_W-1:0]  px_next, py_next, px_reg, py_reg;
    logic signed [PX_W-1:0]  px_rnd, py_rnd;
    logic signed [OFF_W-1:0] offx_reg, offy_reg;
    logic signed [POS_W-1:0] posx_next, posy_next, posx_reg, posy_reg;
    logic signed [POS_W-1:0] posx_rnd, posy_rnd;
    logic signed [SX_W-1:0]  sx_reg, sy_reg;
    logic signed [SX_W-1:0]  width, height;
    logic                    ok;
    src_t                    src_next, src_reg;

    always_comb
    begin
        adv[NSTG] = !dn_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vld_next = {vld_reg[NSTG-2:0], up_valid};
    assign up_stall = !adv[0];
    assign dn_valid = vld_reg[NSTG-1];
    assign dn_data  = src_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    always_comb
    begin
        px_next = up_data.dx * up_data.scale;
        py_next = up_data.dy * up_data.scale;

        px_rnd = px_reg + (px_reg[PX_W-1] ? OFF_BIAS : '0);
        py_rnd = py_reg + (py_reg[PX_W-1] ? OFF_BIAS : '0);

        posx_next = POS_W'(offx_reg) + $signed(POS_W'(cfg.center_x));
        posy_next = POS_W'(offy_reg) + $signed(POS_W'(cfg.center_y));

        posx_rnd = posx_reg + (posx_reg[POS_W-1] ? POS_BIAS : '0);
        posy_rnd = posy_reg + (posy_reg[POS_W-1] ? POS_BIAS : '0);

        width  = $signed(SX_W'(cfg.frame_size[DIM_W-1:0]));
        height = $signed(SX_W'(cfg.frame_size[2*DIM_W-1:DIM_W]));

        // a position just left of zero truncates to zero and counts as inside
        ok = !sx_reg[SX_W-1] && (sx_reg < width) && !sy_reg[SX_W-1] && (sy_reg < height);

        src_next.in_frame   = ok;
        src_next.source_col = ok ? sx_reg[COORD_BITS-1:0] : '0;
        src_next.source_row = ok ? sy_reg[COORD_BITS-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (adv[1])
        begin
            offx_reg <= OFF_W'(px_rnd >>> OFF_SH);
            offy_reg <= OFF_W'(py_rnd >>> OFF_SH);
        end
        if (adv[2])
        begin
            posx_reg <= posx_next;
            posy_reg <= posy_next;
        end
        if (adv[3])
        begin
            sx_reg <= SX_W'(posx_rnd >>> POS_SH);
            sy_reg <= SX_W'(posy_rnd >>> POS_SH);
        end
        if (adv[4])
        begin
            src_reg <= src_next;
        end
    end

endmodule

`default_nettype wire

### src/radial_distortion_remap_top.sv
// Radial lens distortion remap: destination pixel in, source pixel out.
//
// dest channel: dest_valid/dest_stall carry one destination coordinate per
// beat. src channel: src_valid/src_stall carry the source coordinate and the
// in-frame flag; outside the image the coordinates read 0 with in_frame 0.
// A beat moves at a rising edge where valid is high and stall is low.
//
// From an accepted dest beat to the src beat the pipeline has 6 stages for
// the radius, 6 for the three multiply/add steps of the polynomial and 5 for
// the projection and frame test. Unstalled, throughput is one beat per cycle.
// When src_stall holds, the pipeline fills its empty stages first and raises
// dest_stall only once every stage holds a beat; nothing is dropped.
// Reset clears all valid bits and all registers of the APB port to zero.
// Program the registers only while no beat is in flight; pready is always high.
`default_nettype none

module radial_distortion_remap_top
    import rdm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]       prdata,
    output logic                   pready,
    input  wire logic              dest_valid,
    output logic                   dest_stall,
    input  wire dest_t             dest,
    output logic                   src_valid,
    input  wire logic              src_stall,
    output src_t                   src
);

    cfg_t  cfg;
    logic  rad_valid, rad_stall;
    rad_t  rad_data;
    logic  poly_valid, poly_stall;
    poly_t poly_data;

    rdm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rdm_radius u_radius (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dest_valid),
        .up_stall (dest_stall),
        .up_data  (dest),
        .cfg      (cfg),
        .dn_valid (rad_valid),
        .dn_stall (rad_stall),
        .dn_data  (rad_data)
    );

    rdm_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rad_valid),
        .up_stall (rad_stall),
        .up_data  (rad_data),
        .cfg      (cfg),
        .dn_valid (poly_valid),
        .dn_stall (poly_stall),
        .dn_data  (poly_data)
    );

    rdm_project u_project (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (poly_valid),
        .up_stall (poly_stall),
        .up_data  (poly_data),
        .cfg      (cfg),
        .dn_valid (src_valid),
        .dn_stall (src_stall),
        .dn_data  (src)
    );

endmodule

`default_nettype wire

### src/rdm_checker.sv
`include "radial_distortion_remap_top_assert.svh"
`default_nettype none

module rdm_checker
    import rdm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic dest_valid,
    input wire logic dest_stall,
    input wire logic src_valid,
    input wire logic src_stall,
    input wire src_t src,
    input wire logic pready
);

    logic coords_zero;

    assign coords_zero = (src.source_col == '0) && (src.source_row == '0);

    // a stalled result beat holds
    `RDM_ASSERT_NEXT(a_src_hold, src_valid && src_stall, src_valid && $stable(src))

    // outside the image both coordinates read zero
    `RDM_ASSERT_NOW(a_outside_zero, src_valid && !src.in_frame, coords_zero)

    // input backs up only when the pipe is full and the output is held
    `RDM_ASSERT_NOW(a_stall_full, dest_stall, src_valid && src_stall)

    // with input and output both idle, dest_stall is low and pready is high
    `RDM_ASSERT_NOW(a_ready_empty, !src_valid && !dest_valid, !dest_stall && pready)

endmodule

bind radial_distortion_remap_top rdm_checker u_rdm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src        (src),
    .pready     (pready)
);

`default_nettype wire
